// ----- hdl/modbus_holding_register_bank_top_assert.svh -----
// Assertion macros for the holding register bank back end (mhrb_back).
`ifndef MODBUS_HOLDING_REGISTER_BANK_TOP_ASSERT_SVH
`define MODBUS_HOLDING_REGISTER_BANK_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MHRB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mhrb assertion failed: same-cycle check");

// Next-cycle implication, checked outside reset.
`define MHRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mhrb assertion failed: next-cycle check");

`endif

// ----- hdl/mhrb_pkg.sv -----
package mhrb_pkg;

   // Width of index and count fields; covers any bank size up to 63 words.
   localparam int IDX_W = 6;

   localparam logic [15:0] RESET_BASE  = 16'd40001;
   localparam logic [15:0] RESET_WORD0 = 16'd1900;

   localparam logic ACT_READ  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   typedef enum logic [1:0] {
      KIND_COUNT   = 2'd0,
      KIND_WORD    = 2'd1,
      KIND_ILLEGAL = 2'd2,
      KIND_DONE    = 2'd3
   } kind_type;

   typedef struct packed {
      logic        action;
      logic [15:0] start_address;
      logic [15:0] word_count;
      logic [15:0] write_value;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] value;
      logic        last;
   } rsp_type;

   // Classified command handed from front to back.
   typedef struct packed {
      logic             is_write;
      logic             legal;
      logic [7:0]       byte_count;
      logic [IDX_W-1:0] count;
      logic [IDX_W-1:0] index;
      logic [15:0]      write_value;
   } cmd_type;

endpackage

// ----- hdl/mhrb_front.sv -----
module mhrb_front #(
   parameter int NUM_REGS = 40
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [15:0]         csr_write_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  mhrb_pkg::req_type   req_data,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output mhrb_pkg::cmd_type   cmd_data
);

   logic [15:0] base_ff;
   logic [15:0] base_in;
   logic [15:0] span;
   logic [15:0] offset;
   logic [16:0] bank_end;
   logic [16:0] req_end;

   always_comb begin
      base_in = base_ff;
      if (csr_write_enable) begin
         base_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= mhrb_pkg::RESET_BASE;
      end else begin
         base_ff <= base_in;
      end
   end

   // Range check: both ends formed in 17 bits so nothing wraps.
   always_comb begin
      span     = (req_data.action == mhrb_pkg::ACT_WRITE) ? 16'd1 : req_data.word_count;
      bank_end = {1'b0, base_ff} + 17'(NUM_REGS);
      req_end  = {1'b0, req_data.start_address} + {1'b0, span};
      offset   = req_data.start_address - base_ff;

      cmd_data.is_write    = (req_data.action == mhrb_pkg::ACT_WRITE);
      cmd_data.legal       = (req_data.start_address >= base_ff) && (req_end <= bank_end);
      cmd_data.byte_count  = {req_data.word_count[6:0], 1'b0};
      cmd_data.count       = req_data.word_count[mhrb_pkg::IDX_W-1:0];
      cmd_data.index       = offset[mhrb_pkg::IDX_W-1:0];
      cmd_data.write_value = req_data.write_value;
   end

   assign cmd_valid = req_valid;
   assign req_ready = cmd_ready;

endmodule

// ----- hdl/mhrb_queue.sv -----
module mhrb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  mhrb_pkg::cmd_type   push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output mhrb_pkg::cmd_type   pop_data
);

   mhrb_pkg::cmd_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;
   logic       push;
   logic       pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/mhrb_back.sv -----
`include "modbus_holding_register_bank_top_assert.svh"

module mhrb_back #(
   parameter int NUM_REGS = 40
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  mhrb_pkg::cmd_type   cmd_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mhrb_pkg::rsp_type   rsp_data
);

   localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_WORD = 2'b10
   } state_type;

   state_type                 state_ff;
   state_type                 state_in;
   logic [AW-1:0]             addr_ff;
   logic [AW-1:0]             addr_in;
   logic [mhrb_pkg::IDX_W-1:0] remain_ff;
   logic [mhrb_pkg::IDX_W-1:0] remain_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   mhrb_pkg::rsp_type         rsp_ff;
   mhrb_pkg::rsp_type         rsp_in;
   logic                      load;
   logic                      out_free;
   logic                      mem_we;
   logic [AW-1:0]             wr_addr;

   logic [15:0]               mem [NUM_REGS];
   logic [NUM_REGS-1:0]       written_ff;
   logic [15:0]               rd_word_ff;
   logic                      rd_written_ff;
   logic [15:0]               word;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign wr_addr  = cmd_data.index[AW-1:0];
   // Never-written entries read as their reset contents.
   assign word     = rd_written_ff ? rd_word_ff : (mhrb_pkg::RESET_WORD0 + 16'(addr_ff));

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      remain_in    = remain_ff;
      load         = 1'b0;
      mem_we       = 1'b0;
      cmd_ready    = 1'b0;
      rsp_in.kind  = mhrb_pkg::KIND_ILLEGAL;
      rsp_in.value = 16'd0;
      rsp_in.last  = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_ready = 1'b1;
               load      = 1'b1;
               priority if (!cmd_data.legal) begin
                  rsp_in.kind = mhrb_pkg::KIND_ILLEGAL;
               end else if (cmd_data.is_write) begin
                  mem_we      = 1'b1;
                  rsp_in.kind = mhrb_pkg::KIND_DONE;
               end else begin
                  rsp_in.kind  = mhrb_pkg::KIND_COUNT;
                  rsp_in.value = {8'd0, cmd_data.byte_count};
                  rsp_in.last  = (cmd_data.count == '0);
                  addr_in      = cmd_data.index[AW-1:0];
                  remain_in    = cmd_data.count;
                  if (cmd_data.count != '0) begin
                     state_in = S_WORD;
                  end
               end
            end
         end
         S_WORD: begin
            if (out_free) begin
               load         = 1'b1;
               rsp_in.kind  = mhrb_pkg::KIND_WORD;
               rsp_in.value = word;
               rsp_in.last  = (remain_ff == mhrb_pkg::IDX_W'(1));
               remain_in    = remain_ff - mhrb_pkg::IDX_W'(1);
               if (remain_ff == mhrb_pkg::IDX_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  addr_in = addr_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         addr_ff      <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         written_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_we) begin
            written_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Read at the next address so the registered word tracks addr_ff.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= cmd_data.write_value;
      end
      rd_word_ff    <= mem[addr_in];
      rd_written_ff <= written_ff[addr_in];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `MHRB_ASSERT_NOW(a_word_remaining, clock, reset, state_ff == S_WORD, remain_ff != '0)
   `MHRB_ASSERT_NOW(a_word_addr, clock, reset, state_ff == S_WORD,
                    addr_ff <= AW'(NUM_REGS - 1))
   `MHRB_ASSERT_NEXT(a_last_idle, clock, reset, load && rsp_in.last, state_ff == S_IDLE)
   `MHRB_ASSERT_NOW(a_no_pop_busy, clock, reset, state_ff == S_WORD, !cmd_ready)

endmodule

// ----- hdl/modbus_holding_register_bank_top.sv -----
// Channel    Direction  Handshake              Payload
// req_       in         req_valid / req_ready  mhrb_pkg::req_type (read or write request)
// rsp_       out        rsp_valid / rsp_ready  mhrb_pkg::rsp_type (one result item)
// csr_       in         csr_write_enable       csr_write_data (base address)
//
// A write or an illegal request gives one item, after the queue and the back end's output register.
// A legal read of n registers gives n + 1 items, the count item and then one word a cycle
// while rsp_ready allows; the single bank read port sets that pace; no new command is taken meanwhile.
// Reset sets the base address to 40001 and marks every bank word unwritten, so
// word i reads as 1900 + i until it is written; no clearing pass is needed.
// A two-entry command queue lets the request side keep accepting while the
// back end waits on rsp_ready; req_ready drops only when the queue is full.
module modbus_holding_register_bank_top #(
   parameter int NUM_REGS = 40
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [15:0]         csr_write_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  mhrb_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mhrb_pkg::rsp_type   rsp_data
);

   // Front to queue
   logic              fq_valid;
   logic              fq_ready;
   mhrb_pkg::cmd_type fq_data;
   // Queue to back
   logic              qb_valid;
   logic              qb_ready;
   mhrb_pkg::cmd_type qb_data;

   // Classify each item against the base address and range.
   mhrb_front #(
      .NUM_REGS (NUM_REGS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .cmd_valid        (fq_valid),
      .cmd_ready        (fq_ready),
      .cmd_data         (fq_data)
   );

   // Hold classified commands until the back end is free.
   mhrb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   // Execute commands: write the bank or stream words out.
   mhrb_back #(
      .NUM_REGS (NUM_REGS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (qb_valid),
      .cmd_ready (qb_ready),
      .cmd_data  (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
